// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/urx_pkg.sv =====
// package for the uart receiver: constants, phase type and register map
`timescale 1ns / 1ps

package urx_pkg;

    localparam int URX_FIFO_DEPTH = 128;
    localparam int URX_DATA_BITS  = 8;
    localparam int URX_BYTE_W     = 8;
    localparam int URX_TICK_W     = 16;
    localparam int URX_BIDX_W     = 4;

    localparam logic [URX_TICK_W-1:0] URX_BIT_TICKS_RESET = 16'd868;

    localparam int URX_APB_ADDR_W = 3;
    localparam int URX_APB_DATA_W = 32;
    localparam logic [URX_APB_ADDR_W-1:0] URX_REG_BIT_TICKS = 3'd0;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_STOP  = 3'd3,
        PH_AFTER = 3'd4
    } urx_phase_t;

endpackage

// ===== rtl/uart_rx_sampler_fifo.sv =====
// uart 8n1 receiver with receive fifo, top level
//
// input channel s_axis: one transaction per oversampling tick or pop request.
//   tuser = op (0 tick, 1 pop), tdata[0] = receive line level.
// output channel m_axis: exactly one result transaction per input transaction.
//   tuser = read_valid, tdata = read_byte, frame_stored, framing_error, overrun.
// apb port: bit_ticks at byte address 0, to be written by the user only while
//   the block is idle; the block does not enforce this. a result is registered
//   in the cycle after its input is taken while the result register is free,
//   later when parked in the skid entry. throughput: one transaction per cycle
//   when m_axis_tready is high (single register stage, one-write one-read fifo).
// stall: a two-deep path (input skid entry plus result register) keeps taking
//   one more transaction while the result waits; then s_axis_tready drops.
// reset: receiver hunts for a start edge, line taken as idle high, fifo empty,
//   bit_ticks back to 868. fifo memory is not cleared; unread entries are never
//   returned.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module uart_rx_sampler_fifo
    import urx_pkg::*;
#(
    parameter int FIFO_DEPTH = URX_FIFO_DEPTH,
    parameter int DATA_BITS  = URX_DATA_BITS
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [0] rx_level
    input  logic                      s_axis_tuser,   // [0] op
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [7:0] read_byte, [8] frame_stored, [9] framing_error, [10] overrun
    output logic [15:0]               m_axis_tdata,
    output logic                      m_axis_tuser,   // [0] read_valid
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [URX_APB_ADDR_W-1:0] paddr,
    input  logic [URX_APB_DATA_W-1:0] pwdata,
    output logic [URX_APB_DATA_W-1:0] prdata,
    output logic                      pready
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [URX_BIDX_W-1:0] BIDX_END = URX_BIDX_W'(DATA_BITS);

    // configuration
    logic [URX_TICK_W-1:0] bit_ticks_reg;

    // input skid entry
    logic skid_valid_reg;
    logic skid_op_reg;
    logic skid_lvl_reg;

    // receiver state
    urx_phase_t             phase_reg, phase_next;
    logic [URX_TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic [URX_BIDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [URX_BYTE_W-1:0]  shift_byte_reg, shift_byte_next;
    logic                   last_level_reg, last_level_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;

    logic [URX_BYTE_W-1:0]  fifo_mem [FIFO_DEPTH];

    // result register
    logic                   res_valid_reg;
    logic                   res_rvalid_reg;
    logic [URX_BYTE_W-1:0]  res_byte_reg;
    logic                   res_stored_reg;
    logic                   res_ferr_reg;
    logic                   res_ovr_reg;

    // processing control
    logic                   res_free;
    logic                   item_avail;
    logic                   do_proc;
    logic                   item_op;
    logic                   item_lvl;

    logic [URX_TICK_W-1:0]  tick_dec;
    logic [URX_TICK_W-1:0]  half_ticks;
    logic [URX_TICK_W-1:0]  start_wait;
    logic [URX_TICK_W-1:0]  bit_wait;
    logic [URX_BIDX_W-1:0]  bit_index_inc;
    logic [PTR_W-1:0]       wr_ptr_inc;
    logic [PTR_W-1:0]       rd_ptr_inc;
    logic                   fifo_empty;
    logic                   fifo_full;
    logic                   bit_fire;

    logic                   pop_ok;
    logic                   stored_c;
    logic                   ferr_c;
    logic                   ovr_c;

    logic                   cfg_write;

    // apb
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr == URX_REG_BIT_TICKS)
        begin
            prdata = URX_APB_DATA_W'(bit_ticks_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg <= URX_BIT_TICKS_RESET;
        end
        else if (cfg_write && paddr == URX_REG_BIT_TICKS)
        begin
            bit_ticks_reg <= pwdata[URX_TICK_W-1:0];
        end
    end

    // handshake and skid
    assign s_axis_tready = !skid_valid_reg;
    assign res_free      = !res_valid_reg || m_axis_tready;
    assign item_avail    = skid_valid_reg || s_axis_tvalid;
    assign do_proc       = item_avail && res_free;
    assign item_op       = skid_valid_reg ? skid_op_reg  : s_axis_tuser;
    assign item_lvl      = skid_valid_reg ? skid_lvl_reg : s_axis_tdata[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res_free)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (s_axis_tvalid && !res_free)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && s_axis_tvalid && !res_free)
        begin
            skid_op_reg  <= s_axis_tuser;
            skid_lvl_reg <= s_axis_tdata[0];
        end
    end

    // datapath helpers
    assign tick_dec      = (tick_count_reg != '0) ? tick_count_reg - 1'b1 : '0;
    assign half_ticks    = bit_ticks_reg >> 1;
    assign start_wait    = (half_ticks == '0) ? URX_TICK_W'(1) : half_ticks;
    assign bit_wait      = (bit_ticks_reg == '0) ? URX_TICK_W'(1) : bit_ticks_reg;
    assign bit_index_inc = bit_index_reg + 1'b1;
    assign wr_ptr_inc    = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc    = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign fifo_empty    = (rd_ptr_reg == wr_ptr_reg);
    assign fifo_full     = (wr_ptr_inc == rd_ptr_reg);
    assign bit_fire      = !item_op && (phase_reg != PH_HUNT) && (tick_dec == '0);

    // result flags
    always_comb
    begin
        pop_ok   = item_op && !fifo_empty;
        stored_c = 1'b0;
        ferr_c   = 1'b0;
        ovr_c    = 1'b0;
        if (bit_fire && phase_reg == PH_STOP)
        begin
            if (item_lvl)
            begin
                stored_c = !fifo_full;
                ovr_c    = fifo_full;
            end
            else
            begin
                ferr_c = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        last_level_next = last_level_reg;
        wr_ptr_next     = stored_c ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next     = pop_ok ? rd_ptr_inc : rd_ptr_reg;

        if (!item_op)
        begin
            last_level_next = item_lvl;
            if (phase_reg == PH_HUNT)
            begin
                if (last_level_reg && !item_lvl)
                begin
                    phase_next      = PH_START;
                    tick_count_next = start_wait;
                    bit_index_next  = '0;
                    shift_byte_next = '0;
                end
            end
            else if (!bit_fire)
            begin
                tick_count_next = tick_dec;
            end
            else
            begin
                tick_count_next = bit_wait;
                case (phase_reg)
                    PH_START:
                    begin
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (item_lvl && !bit_index_reg[URX_BIDX_W-1])
                        begin
                            shift_byte_next[bit_index_reg[URX_BIDX_W-2:0]] = 1'b1;
                        end
                        bit_index_next = bit_index_inc;
                        if (bit_index_inc >= BIDX_END)
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_STOP:
                    begin
                        shift_byte_next = '0;
                        bit_index_next  = '0;
                        phase_next      = PH_AFTER;
                    end
                    default:
                    begin
                        if (item_lvl)
                        begin
                            phase_next      = PH_HUNT;
                            tick_count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            last_level_reg <= 1'b1;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
        end
        else if (do_proc)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            last_level_reg <= last_level_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
        end
    end

    // fifo memory
    always_ff @(posedge clk)
    begin
        if (do_proc && stored_c)
        begin
            fifo_mem[wr_ptr_reg] <= shift_byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_proc && pop_ok)
        begin
            res_byte_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= item_avail;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_proc)
        begin
            res_rvalid_reg <= pop_ok;
            res_stored_reg <= stored_c;
            res_ferr_reg   <= ferr_c;
            res_ovr_reg    <= ovr_c;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tuser  = res_rvalid_reg;
    assign m_axis_tdata  = {5'b0, res_ovr_reg, res_ferr_reg, res_stored_reg,
                            res_rvalid_reg ? res_byte_reg : {URX_BYTE_W{1'b0}}};

    // checks
    `ASSERT_ALWAYS(a_result_kind, clk, rst_n,
        !res_valid_reg || $onehot0({res_rvalid_reg, res_stored_reg, res_ferr_reg, res_ovr_reg}),
        "result carries more than one event")
    `ASSERT_ALWAYS(a_ptr_range, clk, rst_n,
        (wr_ptr_reg <= PTR_LAST) && (rd_ptr_reg <= PTR_LAST),
        "fifo pointer beyond depth")
    `ASSERT_IMPLIES(a_hunt_idle_count, clk, rst_n,
        phase_reg == PH_HUNT, tick_count_reg == '0,
        "tick counter running while hunting")

endmodule
